[rtl/assert_macros.svh]
// assertion helpers, included by the top-level core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge outside reset
`define MHPQ_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define MHPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/mhpq_pkg.sv]
package mhpq_pkg;

  // heap geometry
  localparam int DEPTH  = 128;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = ADDR_W + 2;
  localparam int DATA_W = 32;
  localparam int OUT_CNT_W = 8;

  localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // action codes
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_REMOVE = 1'b1;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_RM_RD,
    S_RM_LD,
    S_DN_RD,
    S_DN_CMP,
    S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept_ins;
    logic accept_rem;
    logic set_full;
    logic set_empty;
    logic up_read;
    logic up_move;
    logic rm_read;
    logic rm_load;
    logic dn_read;
    logic dn_move;
    logic place;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic up_gt;
    logic no_left;
    logic dn_stay;
    logic out_free;
  } sts_t;

endpackage

[rtl/mhpq_ctrl.sv]
module mhpq_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  logic           in_action,
  output logic           in_ready,
  input  mhpq_pkg::sts_t sts,
  output mhpq_pkg::cmd_t cmd
);

  mhpq_pkg::state_t state;
  mhpq_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mhpq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      mhpq_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_action == mhpq_pkg::ACT_INSERT) begin
            state_next = sts.full ? mhpq_pkg::S_DONE : mhpq_pkg::S_UP_RD;
          end else begin
            state_next = sts.empty ? mhpq_pkg::S_DONE : mhpq_pkg::S_RM_RD;
          end
        end
      end
      mhpq_pkg::S_UP_RD: begin
        state_next = sts.pos_zero ? mhpq_pkg::S_DONE : mhpq_pkg::S_UP_CMP;
      end
      mhpq_pkg::S_UP_CMP: begin
        state_next = sts.up_gt ? mhpq_pkg::S_UP_RD : mhpq_pkg::S_DONE;
      end
      mhpq_pkg::S_RM_RD: begin
        state_next = mhpq_pkg::S_RM_LD;
      end
      mhpq_pkg::S_RM_LD: begin
        state_next = sts.empty ? mhpq_pkg::S_DONE : mhpq_pkg::S_DN_RD;
      end
      mhpq_pkg::S_DN_RD: begin
        state_next = sts.no_left ? mhpq_pkg::S_DONE : mhpq_pkg::S_DN_CMP;
      end
      mhpq_pkg::S_DN_CMP: begin
        state_next = sts.dn_stay ? mhpq_pkg::S_DONE : mhpq_pkg::S_DN_RD;
      end
      mhpq_pkg::S_DONE: begin
        if (sts.out_free) begin
          state_next = mhpq_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = mhpq_pkg::S_IDLE;
      end
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      mhpq_pkg::S_IDLE: begin
        in_ready = !rst;
        if (in_valid && !rst) begin
          if (in_action == mhpq_pkg::ACT_INSERT) begin
            cmd.accept_ins = !sts.full;
            cmd.set_full   = sts.full;
          end else begin
            cmd.accept_rem = !sts.empty;
            cmd.set_empty  = sts.empty;
          end
        end
      end
      mhpq_pkg::S_UP_RD: begin
        cmd.up_read = !sts.pos_zero;
        cmd.place   = sts.pos_zero;
      end
      mhpq_pkg::S_UP_CMP: begin
        cmd.up_move = sts.up_gt;
        cmd.place   = !sts.up_gt;
      end
      mhpq_pkg::S_RM_RD: begin
        cmd.rm_read = 1'b1;
      end
      mhpq_pkg::S_RM_LD: begin
        cmd.rm_load = 1'b1;
      end
      mhpq_pkg::S_DN_RD: begin
        cmd.dn_read = !sts.no_left;
        cmd.place   = sts.no_left;
      end
      mhpq_pkg::S_DN_CMP: begin
        cmd.dn_move = !sts.dn_stay;
        cmd.place   = sts.dn_stay;
      end
      mhpq_pkg::S_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

[rtl/mhpq_dp.sv]
module mhpq_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  mhpq_pkg::data_t                   in_value,
  input  mhpq_pkg::cmd_t                    cmd,
  output mhpq_pkg::sts_t                    sts,
  input  logic                              out_ready,
  output logic                              out_valid,
  output mhpq_pkg::status_t                 out_status,
  output mhpq_pkg::data_t                   out_max,
  output logic [mhpq_pkg::OUT_CNT_W-1:0]    out_count
);

  // heap storage, two read ports and one write port
  logic [mhpq_pkg::DATA_W-1:0] mem [mhpq_pkg::DEPTH];

  logic [mhpq_pkg::CNT_W-1:0]  count;
  logic [mhpq_pkg::ADDR_W-1:0] pos;
  mhpq_pkg::data_t             hold;
  mhpq_pkg::data_t             rd_a;
  mhpq_pkg::data_t             rd_b;
  mhpq_pkg::status_t           res_status;
  mhpq_pkg::data_t             res_value;

  logic [mhpq_pkg::ADDR_W-1:0] parent;
  logic [mhpq_pkg::IDX_W-1:0]  l_idx;
  logic [mhpq_pkg::IDX_W-1:0]  r_idx;
  logic [mhpq_pkg::IDX_W-1:0]  cnt_idx;
  logic                        l_gt;
  logic                        r_ok;
  logic                        take_r;
  mhpq_pkg::data_t             best_lv;
  logic [mhpq_pkg::ADDR_W-1:0] rd_a_addr;
  logic [mhpq_pkg::ADDR_W-1:0] rd_b_addr;
  logic                        wr_en;
  logic [mhpq_pkg::ADDR_W-1:0] wr_addr;
  mhpq_pkg::data_t             wr_data;
  logic [mhpq_pkg::ADDR_W-1:0] child;
  logic [mhpq_pkg::CNT_W+mhpq_pkg::OUT_CNT_W-1:0] cnt_wide;

  // tree index arithmetic
  assign parent  = (pos - mhpq_pkg::ADDR_W'(1)) >> 1;
  assign l_idx   = {1'b0, pos, 1'b1};
  assign r_idx   = l_idx + mhpq_pkg::IDX_W'(1);
  assign cnt_idx = mhpq_pkg::IDX_W'(count);

  // child selection, left wins a tie
  assign l_gt    = rd_a > hold;
  assign best_lv = l_gt ? rd_a : hold;
  assign r_ok    = r_idx < cnt_idx;
  assign take_r  = r_ok && (rd_b > best_lv);
  assign child   = take_r ? r_idx[mhpq_pkg::ADDR_W-1:0] : l_idx[mhpq_pkg::ADDR_W-1:0];

  // status to controller
  assign sts.full     = (count == mhpq_pkg::CNT_W'(mhpq_pkg::DEPTH));
  assign sts.empty    = (count == '0);
  assign sts.pos_zero = (pos == '0);
  assign sts.up_gt    = hold > rd_a;
  assign sts.no_left  = (l_idx >= cnt_idx);
  assign sts.dn_stay  = !l_gt && !take_r;
  assign sts.out_free = !out_valid || out_ready;

  // read address select
  always_comb begin
    rd_a_addr = l_idx[mhpq_pkg::ADDR_W-1:0];
    rd_b_addr = r_idx[mhpq_pkg::ADDR_W-1:0];
    if (cmd.up_read) begin
      rd_a_addr = parent;
    end else if (cmd.rm_read) begin
      rd_a_addr = '0;
      rd_b_addr = count[mhpq_pkg::ADDR_W-1:0];
    end
  end

  // write select
  always_comb begin
    wr_en   = cmd.place || cmd.up_move || cmd.dn_move;
    wr_addr = pos;
    wr_data = hold;
    if (cmd.up_move) begin
      wr_data = rd_a;
    end else if (cmd.dn_move) begin
      wr_data = take_r ? rd_b : rd_a;
    end
  end

  // memory access
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[rd_a_addr];
    rd_b <= mem[rd_b_addr];
  end

  // entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.accept_ins) begin
      count <= count + mhpq_pkg::CNT_W'(1);
    end else if (cmd.accept_rem) begin
      count <= count - mhpq_pkg::CNT_W'(1);
    end
  end

  // moving entry, hole position and result scratch
  always_ff @(posedge clk) begin
    if (cmd.accept_ins) begin
      hold <= in_value;
      pos  <= count[mhpq_pkg::ADDR_W-1:0];
    end else if (cmd.up_move) begin
      pos <= parent;
    end else if (cmd.rm_load) begin
      hold <= rd_b;
      pos  <= '0;
    end else if (cmd.dn_move) begin
      pos <= child;
    end
    if (cmd.accept_ins || cmd.accept_rem) begin
      res_status <= mhpq_pkg::ST_OK;
      res_value  <= mhpq_pkg::INT_MIN;
    end else if (cmd.set_full) begin
      res_status <= mhpq_pkg::ST_FULL;
      res_value  <= mhpq_pkg::INT_MIN;
    end else if (cmd.set_empty) begin
      res_status <= mhpq_pkg::ST_EMPTY;
      res_value  <= mhpq_pkg::INT_MIN;
    end else if (cmd.rm_load) begin
      res_value <= rd_a;
    end
  end

  assign cnt_wide = {{mhpq_pkg::OUT_CNT_W{1'b0}}, count};

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status <= res_status;
      out_max    <= res_value;
      out_count  <= cnt_wide[mhpq_pkg::OUT_CNT_W-1:0];
    end
  end

endmodule

[rtl/max_heap_priority_queue_core.sv]
// binary max-heap priority queue of signed 32-bit values, up to 128 entries
// input channel s_*: one transaction per operation; s_tuser is the action
//   (0 insert s_tdata, 1 remove the maximum), s_tdata carries the value
// output channel m_*: exactly one transaction per operation, in order;
//   m_tuser is the status (0 ok, 1 full on insert, 2 empty on remove),
//   m_tdata holds the removed maximum and the entry count after the operation
// insert into a full heap and remove from an empty heap leave it unchanged;
//   the maximum field reads as the most negative value on those and on inserts
// one operation at a time: a sift walks one heap level per read and compare
//   step (registered memory read, then compare and write back); the next
//   operation can be accepted in the cycle after the result is loaded
// the output register lets a new operation be accepted while the previous
//   result still waits; a stalled receiver holds the finished result and the
//   core waits before returning to accept more
// reset (rst, synchronous) empties the heap and drops any pending result;
//   s_tready stays low during reset; no memory clearing is needed
`include "assert_macros.svh"

module max_heap_priority_queue_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [0:0]  s_tuser,   // [0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] max_value, [39:32] count
  output logic [1:0]  m_tuser    // [1:0] status
);

  mhpq_pkg::cmd_t                     cmd;
  mhpq_pkg::sts_t                     sts;
  mhpq_pkg::status_t                  out_status;
  mhpq_pkg::data_t                    out_max;
  logic [mhpq_pkg::OUT_CNT_W-1:0]     out_count;
  mhpq_pkg::data_t                    in_value;

  assign in_value = mhpq_pkg::data_t'(s_tdata);

  // sequencer
  mhpq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_action (s_tuser[0]),
    .in_ready  (s_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // heap memory and registers
  mhpq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_value   (in_value),
    .cmd        (cmd),
    .sts        (sts),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_status (out_status),
    .out_max    (out_max),
    .out_count  (out_count)
  );

  // output packing
  assign m_tdata = {out_count, out_max};
  assign m_tuser = out_status;

  // checks
  `MHPQ_ASSERT(a_one_write, $onehot0({cmd.place, cmd.up_move, cmd.dn_move}), "two heap writes at once")
  `MHPQ_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready, "accepted while busy")
  `MHPQ_ASSERT(a_empty_result, !(m_tvalid && (m_tuser == mhpq_pkg::ST_EMPTY)) || ((m_tdata[31:0] == mhpq_pkg::INT_MIN) && (m_tdata[39:32] == 8'd0)), "bad empty result")
  `MHPQ_ASSERT(a_load_free, !cmd.out_load || !m_tvalid || m_tready, "result overwritten")

endmodule
